### hdl/ep2cal_pkg.sv
// Package for the epoch seconds to calendar conversion unit.
// Holds the shared constants, step select codes, control/status structs and the month table.
// No dependencies.
`default_nettype none

package ep2cal_pkg;

    localparam int SecsPerDay = 86400;
    localparam int SecsPerHour = 3600;
    localparam int SecsPerMin = 60;

    localparam int RemW = 34;   // signed width of the adjusted time
    localparam int StepW = 25;  // widest step is one leap year of seconds

    localparam logic [16:0] ZONE_RESET = 17'd28800;
    localparam logic [11:0] FIRST_YEAR = 12'd1970;
    // Residues of 1970 modulo 4, 100 and 400 for the leap rule counters.
    localparam logic [1:0] FIRST_Y4 = 2'd2;
    localparam logic [6:0] FIRST_Y100 = 7'd70;
    localparam logic [8:0] FIRST_Y400 = 9'd370;

    localparam logic [2:0] STEP_YEAR = 3'd0;
    localparam logic [2:0] STEP_MONTH = 3'd1;
    localparam logic [2:0] STEP_DAY = 3'd2;
    localparam logic [2:0] STEP_HOUR = 3'd3;
    localparam logic [2:0] STEP_MIN = 3'd4;

    typedef struct packed {
        logic       ld_in;
        logic       ld_sum;
        logic       sub_en;
        logic [2:0] step_sel;
        logic       leap;
        logic [3:0] month;
    } t_alu_ctrl;

    typedef struct packed {
        logic       neg;
        logic       ge;
        logic [5:0] low6;
    } t_alu_stat;

    function automatic logic [StepW-1:0] month_secs(input logic [3:0] month, input logic leap);
        logic [StepW-1:0] secs;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: secs = StepW'(30 * SecsPerDay);
            4'd2: secs = leap ? StepW'(29 * SecsPerDay) : StepW'(28 * SecsPerDay);
            default: secs = StepW'(31 * SecsPerDay);
        endcase
        return secs;
    endfunction

endpackage

`default_nettype wire

### hdl/epoch_seconds_to_calendar_unit.sv
// Epoch seconds to Gregorian calendar conversion, one subtract/compare unit reused by a sequencer.
// The strobe follows the sum and sign check and then the year, month, day, hour and minute loops;
// a negative adjusted time gives its strobe straight after the sign check.
// One conversion at a time: busy drops in the cycle the result is shown, and the next
// transaction can be taken in that cycle. The receiver cannot stall. Synchronous active-low
// reset returns the sequencer to idle and the zone offset to eight hours. Uses the ep2cal modules.
`default_nettype none

module epoch_seconds_to_calendar_unit (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire  [31:0]        i_epoch_seconds,
    input  wire  signed [15:0] i_day_offset,
    input  wire                i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire  signed [16:0] i_cfg_data,
    output logic               o_valid,
    output logic [11:0]        o_year,
    output logic [3:0]         o_month,
    output logic [4:0]         o_day_of_month,
    output logic [4:0]         o_hour,
    output logic [5:0]         o_minute,
    output logic [5:0]         o_second_of_minute,
    output logic               o_range_error
);

    logic signed [16:0]    r_zone;
    ep2cal_pkg::t_alu_ctrl ctrl;
    ep2cal_pkg::t_alu_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ep2cal_pkg::ZONE_RESET;
        end else if (i_cfg_valid) begin
            r_zone <= i_cfg_data;
        end
    end

    ep2cal_alu u_alu (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_epoch_seconds (i_epoch_seconds),
        .i_day_offset    (i_day_offset),
        .i_zone          (r_zone),
        .o_stat          (stat)
    );

    ep2cal_seq u_seq (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_start            (start),
        .i_stat             (stat),
        .o_ctrl             (ctrl),
        .o_busy             (busy),
        .o_valid            (o_valid),
        .o_year             (o_year),
        .o_month            (o_month),
        .o_day_of_month     (o_day_of_month),
        .o_hour             (o_hour),
        .o_minute           (o_minute),
        .o_second_of_minute (o_second_of_minute),
        .o_range_error      (o_range_error)
    );

endmodule

`default_nettype wire

### hdl/ep2cal_alu.sv
// Remainder register with the shared compare/subtract unit of the conversion.
// Forms the adjusted time, then peels off years, months, days, hours and minutes.
// Depends on ep2cal_pkg.
`default_nettype none

module ep2cal_alu (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  ep2cal_pkg::t_alu_ctrl      i_ctrl,
    input  wire  [31:0]                i_epoch_seconds,
    input  wire  signed [15:0]         i_day_offset,
    input  wire  signed [16:0]         i_zone,
    output ep2cal_pkg::t_alu_stat      o_stat
);

    localparam int RW = ep2cal_pkg::RemW;
    localparam int SW = ep2cal_pkg::StepW;
    localparam logic signed [17:0] DAY_SECS = 18'sd86400;

    logic signed [RW-1:0] r_prod;
    logic signed [RW-1:0] r_base;
    logic signed [RW-1:0] r_rem;
    logic signed [RW-1:0] n_prod;
    logic signed [RW-1:0] n_base;
    logic [SW-1:0]        step;
    logic                 ge;

    assign n_prod = i_day_offset * DAY_SECS;
    assign n_base = $signed({2'b00, i_epoch_seconds}) + $signed({{17{i_zone[16]}}, i_zone});

    always_comb begin
        case (i_ctrl.step_sel)
            ep2cal_pkg::STEP_YEAR: begin
                step = i_ctrl.leap ? SW'(366 * ep2cal_pkg::SecsPerDay)
                                   : SW'(365 * ep2cal_pkg::SecsPerDay);
            end
            ep2cal_pkg::STEP_MONTH: step = ep2cal_pkg::month_secs(i_ctrl.month, i_ctrl.leap);
            ep2cal_pkg::STEP_DAY:   step = SW'(ep2cal_pkg::SecsPerDay);
            ep2cal_pkg::STEP_HOUR:  step = SW'(ep2cal_pkg::SecsPerHour);
            ep2cal_pkg::STEP_MIN:   step = SW'(ep2cal_pkg::SecsPerMin);
            default:                step = SW'(ep2cal_pkg::SecsPerMin);
        endcase
    end

    // Only the magnitude bits are compared; the sign has been checked before the loops run.
    assign ge = r_rem[RW-2:0] >= {{(RW-1-SW){1'b0}}, step};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_in) begin
            r_prod <= n_prod;
            r_base <= n_base;
        end
        if (i_ctrl.ld_sum) begin
            r_rem <= r_base + r_prod;
        end else if (i_ctrl.sub_en) begin
            r_rem <= r_rem - $signed({{(RW-SW){1'b0}}, step});
        end
    end

    assign o_stat.neg = r_rem[RW-1];
    assign o_stat.ge = ge & i_rst_n;
    assign o_stat.low6 = r_rem[5:0];

endmodule

`default_nettype wire

### hdl/ep2cal_seq.sv
// Sequencer of the conversion: walks the shared unit through the year, month, day,
// hour and minute loops, keeps the calendar counters and registers the result.
// Depends on ep2cal_pkg.
`default_nettype none

module ep2cal_seq (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  ep2cal_pkg::t_alu_stat  i_stat,
    output ep2cal_pkg::t_alu_ctrl  o_ctrl,
    output logic                   o_busy,
    output logic                   o_valid,
    output logic [11:0]            o_year,
    output logic [3:0]             o_month,
    output logic [4:0]             o_day_of_month,
    output logic [4:0]             o_hour,
    output logic [5:0]             o_minute,
    output logic [5:0]             o_second_of_minute,
    output logic                   o_range_error
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SUM   = 3'd1;
    localparam logic [2:0] ST_CHK   = 3'd2;
    localparam logic [2:0] ST_YEAR  = 3'd3;
    localparam logic [2:0] ST_MONTH = 3'd4;
    localparam logic [2:0] ST_DAY   = 3'd5;
    localparam logic [2:0] ST_HOUR  = 3'd6;
    localparam logic [2:0] ST_MIN   = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [11:0] r_year;
    logic [1:0]  r_y4;
    logic [6:0]  r_y100;
    logic [8:0]  r_y400;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;
    logic        r_valid;
    logic [11:0] r_o_year;
    logic [3:0]  r_o_month;
    logic [4:0]  r_o_day;
    logic [4:0]  r_o_hour;
    logic [5:0]  r_o_min;
    logic [5:0]  r_o_sec;
    logic        r_o_err;

    logic accept;
    logic leap;
    logic take;
    logic done_ok;
    logic done_err;

    assign accept = i_start & (r_state == ST_IDLE);
    assign leap = (r_y4 == 2'd0) & ((r_y100 != 7'd0) | (r_y400 == 9'd0));
    // A step is taken while the remainder still covers it; December never subtracts.
    assign take = i_stat.ge & ~((r_state == ST_MONTH) & (r_month == 4'd12));
    assign done_ok = (r_state == ST_MIN) & ~i_stat.ge;
    assign done_err = (r_state == ST_CHK) & i_stat.neg;

    always_comb begin
        o_ctrl.ld_in = accept;
        o_ctrl.ld_sum = (r_state == ST_SUM);
        o_ctrl.sub_en = 1'b0;
        o_ctrl.step_sel = ep2cal_pkg::STEP_YEAR;
        o_ctrl.leap = leap;
        o_ctrl.month = r_month;
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_SUM;
            end
            ST_SUM: n_state = ST_CHK;
            ST_CHK: n_state = i_stat.neg ? ST_IDLE : ST_YEAR;
            ST_YEAR: begin
                o_ctrl.step_sel = ep2cal_pkg::STEP_YEAR;
                o_ctrl.sub_en = take;
                if (!take) n_state = ST_MONTH;
            end
            ST_MONTH: begin
                o_ctrl.step_sel = ep2cal_pkg::STEP_MONTH;
                o_ctrl.sub_en = take;
                if (!take) n_state = ST_DAY;
            end
            ST_DAY: begin
                o_ctrl.step_sel = ep2cal_pkg::STEP_DAY;
                o_ctrl.sub_en = take;
                if (!take) n_state = ST_HOUR;
            end
            ST_HOUR: begin
                o_ctrl.step_sel = ep2cal_pkg::STEP_HOUR;
                o_ctrl.sub_en = take;
                if (!take) n_state = ST_MIN;
            end
            ST_MIN: begin
                o_ctrl.step_sel = ep2cal_pkg::STEP_MIN;
                o_ctrl.sub_en = take;
                if (!take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= done_ok | done_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_year <= ep2cal_pkg::FIRST_YEAR;
            r_y4 <= ep2cal_pkg::FIRST_Y4;
            r_y100 <= ep2cal_pkg::FIRST_Y100;
            r_y400 <= ep2cal_pkg::FIRST_Y400;
            r_month <= 4'd1;
            r_day <= 5'd1;
            r_hour <= 5'd0;
            r_min <= 6'd0;
        end else if (take) begin
            case (r_state)
                ST_YEAR: begin
                    r_year <= r_year + 12'd1;
                    r_y4 <= r_y4 + 2'd1;
                    r_y100 <= (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
                    r_y400 <= (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                end
                ST_MONTH: r_month <= r_month + 4'd1;
                ST_DAY:   r_day <= r_day + 5'd1;
                ST_HOUR:  r_hour <= r_hour + 5'd1;
                ST_MIN:   r_min <= r_min + 6'd1;
                default: begin
                    r_year <= r_year;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_err) begin
            r_o_year <= 12'd0;
            r_o_month <= 4'd0;
            r_o_day <= 5'd0;
            r_o_hour <= 5'd0;
            r_o_min <= 6'd0;
            r_o_sec <= 6'd0;
            r_o_err <= 1'b1;
        end else if (done_ok) begin
            r_o_year <= r_year;
            r_o_month <= r_month;
            r_o_day <= r_day;
            r_o_hour <= r_hour;
            r_o_min <= r_min;
            r_o_sec <= i_stat.low6;
            r_o_err <= 1'b0;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_year = r_o_year;
    assign o_month = r_o_month;
    assign o_day_of_month = r_o_day;
    assign o_hour = r_o_hour;
    assign o_minute = r_o_min;
    assign o_second_of_minute = r_o_sec;
    assign o_range_error = r_o_err;

endmodule

`default_nettype wire

### hdl/ep2cal_chk.sv
// Port-level checker for the calendar conversion unit, bound to the top level.
// Depends only on the ports of epoch_seconds_to_calendar_unit.
`default_nettype none

module ep2cal_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_valid,
    input wire [11:0] o_year,
    input wire [3:0]  o_month,
    input wire [4:0]  o_day_of_month,
    input wire [4:0]  o_hour,
    input wire [5:0]  o_minute,
    input wire [5:0]  o_second_of_minute,
    input wire        o_range_error
);

    // A taken transaction makes the unit busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // The unit leaves busy exactly when it presents a result.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(busy) |-> o_valid)
        else $error("busy fell without a result strobe");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe lasted more than one cycle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_range_error |-> o_year == 12'd0 && o_month == 4'd0 &&
            o_day_of_month == 5'd0 && o_hour == 5'd0 && o_minute == 6'd0 &&
            o_second_of_minute == 6'd0)
        else $error("range error with nonzero fields");

    a_fields_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |-> o_year >= 12'd1970 && o_month >= 4'd1 &&
            o_month <= 4'd12 && o_day_of_month >= 5'd1 && o_hour <= 5'd23 &&
            o_minute <= 6'd59 && o_second_of_minute <= 6'd59)
        else $error("calendar field out of range");

endmodule

bind epoch_seconds_to_calendar_unit ep2cal_chk u_ep2cal_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .start              (start),
    .busy               (busy),
    .o_valid            (o_valid),
    .o_year             (o_year),
    .o_month            (o_month),
    .o_day_of_month     (o_day_of_month),
    .o_hour             (o_hour),
    .o_minute           (o_minute),
    .o_second_of_minute (o_second_of_minute),
    .o_range_error      (o_range_error)
);

`default_nettype wire

### bench/calendar_checker.sv
// Checker for the epoch seconds to calendar unit: watches the command, zone write and result ports.
// Predicts each calendar date from the accepted timestamp and compares it with the strobed result.
// Depends only on the port list of epoch_seconds_to_calendar_unit.
`timescale 1ns / 100ps

module calendar_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire               busy,
    input  wire        [31:0] i_epoch_seconds,
    input  wire signed [15:0] i_day_offset,
    input  wire               i_cfg_valid,
    input  wire               o_cfg_ready,
    input  wire signed [16:0] i_cfg_data,
    input  wire               o_valid,
    input  wire        [11:0] o_year,
    input  wire         [3:0] o_month,
    input  wire         [4:0] o_day_of_month,
    input  wire         [4:0] o_hour,
    input  wire         [5:0] o_minute,
    input  wire         [5:0] o_second_of_minute,
    input  wire               o_range_error,
    output int                mismatch_count,
    output int                dates_in_flight
);

    localparam logic signed [16:0] ZoneAtReset = 17'sd28800;
    localparam longint DaySecs = 86400;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second_of_minute;
        logic        range_error;
    } cal_date_t;

    logic signed [16:0] zone_seconds = ZoneAtReset;
    cal_date_t          expected_dates[$];
    cal_date_t          want;
    int                 fails = 0;

    assign mismatch_count = fails;

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic longint month_length(input int unsigned mo, input int unsigned yr);
        longint n;
        case (mo)
            2: n = leap_year(yr) ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default: n = 31;
        endcase
        return n * DaySecs;
    endfunction

    function automatic cal_date_t to_calendar(input logic [31:0] secs,
                                              input logic signed [15:0] days,
                                              input logic signed [16:0] zone);
        longint      t;
        longint      span;
        int unsigned yr;
        int unsigned mo;
        bit          done;
        cal_date_t   r;
        r = '0;
        t = longint'({32'd0, secs}) + longint'(days) * DaySecs + longint'(zone);
        if (t < 0) begin
            // A time before the epoch has no date; only the error flag is set.
            r.range_error = 1'b1;
        end else begin
            yr = 1970;
            span = (leap_year(yr) ? 366 : 365) * DaySecs;
            while (t >= span) begin
                t = t - span;
                yr = yr + 1;
                span = (leap_year(yr) ? 366 : 365) * DaySecs;
            end
            mo = 1;
            done = 1'b0;
            while (mo < 12 && !done) begin
                span = month_length(mo, yr);
                if (t < span) begin
                    done = 1'b1;
                end else begin
                    t = t - span;
                    mo = mo + 1;
                end
            end
            r.year = 12'(yr);
            r.month = 4'(mo);
            r.day_of_month = 5'(t / DaySecs + 1);
            t = t % DaySecs;
            r.hour = 5'(t / 3600);
            r.minute = 6'((t % 3600) / 60);
            r.second_of_minute = 6'(t % 60);
        end
        return r;
    endfunction

    task automatic report(input string field, input longint got, input longint exp_val);
        if (fails < 100) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got,
                     exp_val);
        end
        fails = fails + 1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            zone_seconds <= ZoneAtReset;
            expected_dates.delete();
            dates_in_flight <= 0;
        end else begin
            // The result is checked before a new command is queued, since both
            // transactions may fall on the same edge.
            if (o_valid) begin
                if (expected_dates.size() == 0) begin
                    report("result with nothing pending, year", o_year, 0);
                end else begin
                    want = expected_dates.pop_front();
                    if (o_year !== want.year) report("year", o_year, want.year);
                    if (o_month !== want.month) report("month", o_month, want.month);
                    if (o_day_of_month !== want.day_of_month)
                        report("day_of_month", o_day_of_month, want.day_of_month);
                    if (o_hour !== want.hour) report("hour", o_hour, want.hour);
                    if (o_minute !== want.minute) report("minute", o_minute, want.minute);
                    if (o_second_of_minute !== want.second_of_minute)
                        report("second_of_minute", o_second_of_minute, want.second_of_minute);
                    if (o_range_error !== want.range_error)
                        report("range_error", o_range_error, want.range_error);
                end
            end
            if (start && !busy) begin
                expected_dates.push_back(to_calendar(i_epoch_seconds, i_day_offset,
                                                     zone_seconds));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                zone_seconds <= i_cfg_data;
            end
            dates_in_flight <= expected_dates.size();
        end
    end

endmodule

### bench/testbench.sv
// Top of the bench for epoch_seconds_to_calendar_unit: clock, reset, zone writes and commands.
// Results are predicted and compared by calendar_checker, which returns the failure count.
`timescale 1ns / 100ps

module testbench;

    localparam int     RandomPerPhase = 148;
    localparam int     SettleCycles = 400;
    localparam longint CycleLimit = 3000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic        [31:0] epoch_seconds = '0;
    logic signed [15:0] day_offset = '0;
    logic               cfg_valid = 1'b0;
    logic signed [16:0] cfg_data = '0;

    wire                busy;
    wire                o_cfg_ready;
    wire                o_valid;
    wire         [11:0] o_year;
    wire          [3:0] o_month;
    wire          [4:0] o_day_of_month;
    wire          [4:0] o_hour;
    wire          [5:0] o_minute;
    wire          [5:0] o_second_of_minute;
    wire                o_range_error;

    int                 mismatch_count;
    int                 dates_in_flight;
    longint             cycles = 0;
    logic signed [16:0] zone_now = 17'sd28800;
    bit                 back_to_back = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    epoch_seconds_to_calendar_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_epoch_seconds    (epoch_seconds),
        .i_day_offset       (day_offset),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_valid            (o_valid),
        .o_year             (o_year),
        .o_month            (o_month),
        .o_day_of_month     (o_day_of_month),
        .o_hour             (o_hour),
        .o_minute           (o_minute),
        .o_second_of_minute (o_second_of_minute),
        .o_range_error      (o_range_error)
    );

    calendar_checker date_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_epoch_seconds    (epoch_seconds),
        .i_day_offset       (day_offset),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (cfg_data),
        .o_valid            (o_valid),
        .o_year             (o_year),
        .o_month            (o_month),
        .o_day_of_month     (o_day_of_month),
        .o_hour             (o_hour),
        .o_minute           (o_minute),
        .o_second_of_minute (o_second_of_minute),
        .o_range_error      (o_range_error),
        .mismatch_count     (mismatch_count),
        .dates_in_flight    (dates_in_flight)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Start stays high from one accepted command to the next when no gap is drawn.
    task automatic convert(input logic [31:0] secs, input logic signed [15:0] days);
        int gap;
        if ($urandom_range(0, 19) == 0) back_to_back = !back_to_back;
        gap = back_to_back ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        epoch_seconds <= secs;
        day_offset <= days;
        do @(posedge i_clk); while (busy);
    endtask

    // The zone is only changed once every pending date has come back.
    task automatic write_zone(input logic signed [16:0] value);
        start <= 1'b0;
        do @(posedge i_clk); while (dates_in_flight != 0);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        zone_now = value;
    endtask

    task automatic random_phase();
        logic        [31:0] secs;
        logic signed [15:0] days;
        longint             k;
        repeat (RandomPerPhase) begin
            case ($urandom_range(0, 9))
                5, 6: begin
                    // Around the epoch, where the zone decides the sign.
                    secs = $urandom_range(0, 300000);
                    days = 16'(-int'($urandom_range(0, 4)));
                end
                7: begin
                    // Local midnight, or one second before it.
                    k = longint'($urandom_range(1, 49000)) * 86400 - longint'(zone_now)
                        - longint'($urandom_range(0, 1));
                    secs = k[31:0];
                    days = 16'($urandom_range(0, 3));
                end
                8: begin
                    secs = $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
                    days = 16'($urandom_range(0, 32767));
                end
                9: begin
                    secs = $urandom;
                    days = 16'(int'($urandom_range(0, 10)) - 5);
                end
                default: begin
                    secs = $urandom;
                    days = 16'($urandom);
                end
            endcase
            convert(secs, days);
        end
    endtask

    task automatic extreme_phase(input logic signed [16:0] value);
        write_zone(value);
        convert(32'd0, 16'sd0);
        convert(32'hFFFF_FFFF, 16'sd32767);
        random_phase();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zone left at its reset value of eight hours.
        random_phase();

        write_zone(17'sd0);
        convert(32'd0, 16'sd0);
        convert(32'd0, -16'sd1);
        convert(32'd86399, -16'sd1);
        convert(32'd86400, -16'sd1);
        convert(32'hFFFF_FFFF, 16'sd0);
        convert(32'hFFFF_FFFF, 16'sd32767);
        convert(32'hFFFF_FFFF, -16'sd32768);
        convert(32'd0, 16'sd32767);
        convert(32'h5555_5555, 16'sh5555);
        convert(32'hAAAA_AAAA, 16'shAAAA);
        // Leap day in an ordinary leap year, a leap century and a common century.
        convert(32'd68169599, 16'sd0);
        convert(32'd68169600, 16'sd0);
        convert(32'd946684799, 16'sd0);
        convert(32'd946684800, 16'sd0);
        convert(32'd951782400, 16'sd0);
        convert(32'd951868800, 16'sd0);
        convert(32'd4107542399, 16'sd0);
        convert(32'd4107542400, 16'sd0);
        random_phase();

        extreme_phase(-17'sd43200);
        extreme_phase(17'sd50400);
        // Values beyond the documented range are used as plain two's complement.
        extreme_phase(17'sh10000);
        extreme_phase(17'sh0FFFF);

        repeat (3) begin
            write_zone(17'(int'($urandom_range(0, 93600)) - 43200));
            random_phase();
        end

        start <= 1'b0;
        do @(posedge i_clk); while (dates_in_flight != 0);
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0 && dates_in_flight == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
hdl/ep2cal_pkg.sv
hdl/ep2cal_alu.sv
hdl/ep2cal_seq.sv
hdl/epoch_seconds_to_calendar_unit.sv
hdl/ep2cal_chk.sv
bench/calendar_checker.sv
bench/testbench.sv
